@@ design/u2uj_pkg.sv @@
// Package: types, constants and encode functions for the UTF-16 to UTF-8 JSON escaper.
`timescale 1ns / 1ps

package u2uj_pkg;

    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [20:0] LIMIT_1BYTE   = 21'h00080;
    localparam logic [20:0] LIMIT_2BYTE   = 21'h00800;
    localparam logic [20:0] LIMIT_3BYTE   = 21'h10000;

    localparam logic [7:0] ESC_LEAD   = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] ESC_LF     = 8'h6E;
    localparam logic [7:0] ESC_CR     = 8'h72;
    localparam logic [7:0] ESC_TAB    = 8'h74;

    localparam logic [7:0] LEAD_2BYTE = 8'hC0;
    localparam logic [7:0] LEAD_3BYTE = 8'hE0;
    localparam logic [7:0] LEAD_4BYTE = 8'hF0;
    localparam logic [7:0] CONT_BYTE  = 8'h80;

    // U+FFFD as UTF-8
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam int unsigned MAX_BYTES = 6;

    // Bytes of one code point; b[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } cp_bytes_t;

    // Everything one code unit produces, plus the surrogate state it leaves.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      pending;
        logic [9:0]                held;
    } enc_res_t;

    function automatic cp_bytes_t encode_cp(input logic [20:0] cp);
        cp_bytes_t r;
        r = '0;
        if (cp < LIMIT_1BYTE) begin
            priority if (cp[7:0] == CH_QUOTE) begin
                r.b[0] = ESC_LEAD;
                r.b[1] = CH_QUOTE;
                r.n    = 3'd2;
            end else if (cp[7:0] == CH_BSLASH) begin
                r.b[0] = ESC_LEAD;
                r.b[1] = CH_BSLASH;
                r.n    = 3'd2;
            end else if (cp[7:0] == CH_LF) begin
                r.b[0] = ESC_LEAD;
                r.b[1] = ESC_LF;
                r.n    = 3'd2;
            end else if (cp[7:0] == CH_CR) begin
                r.b[0] = ESC_LEAD;
                r.b[1] = ESC_CR;
                r.n    = 3'd2;
            end else if (cp[7:0] == CH_TAB) begin
                r.b[0] = ESC_LEAD;
                r.b[1] = ESC_TAB;
                r.n    = 3'd2;
            end else begin
                r.b[0] = cp[7:0];
                r.n    = 3'd1;
            end
        end else if (cp < LIMIT_2BYTE) begin
            r.b[0] = LEAD_2BYTE | {3'b000, cp[10:6]};
            r.b[1] = CONT_BYTE  | {2'b00, cp[5:0]};
            r.n    = 3'd2;
        end else if (cp < LIMIT_3BYTE) begin
            r.b[0] = LEAD_3BYTE | {4'h0, cp[15:12]};
            r.b[1] = CONT_BYTE  | {2'b00, cp[11:6]};
            r.b[2] = CONT_BYTE  | {2'b00, cp[5:0]};
            r.n    = 3'd3;
        end else begin
            r.b[0] = LEAD_4BYTE | {5'b00000, cp[20:18]};
            r.b[1] = CONT_BYTE  | {2'b00, cp[17:12]};
            r.b[2] = CONT_BYTE  | {2'b00, cp[11:6]};
            r.b[3] = CONT_BYTE  | {2'b00, cp[5:0]};
            r.n    = 3'd4;
        end
        return r;
    endfunction

    function automatic enc_res_t encode_unit(
        input logic [15:0] unit,
        input logic        last,
        input logic        pending,
        input logic [9:0]  held
    );
        enc_res_t  r;
        cp_bytes_t cur;
        logic      is_high;
        logic      is_low;
        r       = '0;
        cur     = '0;
        is_high = (unit[15:10] == HIGH_SURR_TAG);
        is_low  = (unit[15:10] == LOW_SURR_TAG);
        if (pending && is_low) begin
            // Pair completes: one supplementary code point
            cur          = encode_cp(SUPP_BASE + {1'b0, held, unit[9:0]});
            r.bytes[3:0] = cur.b;
            r.count      = cur.n;
        end else begin
            if (is_high && !last) begin
                cur = '0;
            end else if (is_high || is_low) begin
                cur.b[0] = REPL_B0;
                cur.b[1] = REPL_B1;
                cur.b[2] = REPL_B2;
                cur.n    = 3'd3;
            end else begin
                cur = encode_cp({5'b00000, unit});
            end
            if (pending) begin
                // Unpaired held high surrogate goes out first as U+FFFD
                r.bytes[0]   = REPL_B0;
                r.bytes[1]   = REPL_B1;
                r.bytes[2]   = REPL_B2;
                r.bytes[5:3] = cur.b[2:0];
                r.count      = 3'd3 + cur.n;
            end else begin
                r.bytes[3:0] = cur.b;
                r.count      = cur.n;
            end
            r.pending = is_high && !last;
            r.held    = (is_high && !last) ? unit[9:0] : 10'd0;
        end
        return r;
    endfunction

endpackage

@@ design/u2uj_ifs.sv @@
// Interfaces: UTF-16 code unit channel and UTF-8 byte channel.
`timescale 1ns / 1ps

interface u2uj_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        string_last;

    modport source (output valid, output code_unit, output string_last, input ready);
    modport sink   (input valid, input code_unit, input string_last, output ready);
endinterface

interface u2uj_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface

@@ design/utf16_to_utf8_json_escape.sv @@
// Top level: streaming UTF-16 to UTF-8 transcoder with JSON escapes.
`timescale 1ns / 1ps
// With the byte buffer free, a code unit is captured in the input register and then
//   loaded into the byte buffer, from which its first byte is offered.
// Throughput: one code unit per cycle while each makes at most one byte and byte_ch is
//   ready; a unit that makes more bytes holds the byte buffer until its last byte leaves.
// A held high surrogate makes no byte and still passes through the buffer stage.
// Reset (rst_n low, asynchronous) empties both stages and drops any held surrogate.

module utf16_to_utf8_json_escape (
    input  logic               clk,
    input  logic               rst_n,
    u2uj_unit_if.sink          unit_ch,
    u2uj_byte_if.source        byte_ch
);
    import u2uj_pkg::*;

    // Input stage: one registered code unit waiting to be encoded
    logic        in_vld_reg, in_vld_next;
    logic [15:0] unit_reg;
    logic        last_reg;

    // Surrogate state
    logic        pend_reg, pend_next;
    logic [9:0]  held_reg, held_next;

    // Byte buffer: up to six bytes of one unit, shifted out from entry 0
    logic [MAX_BYTES-1:0][7:0] buf_reg, buf_next;
    logic [2:0]                cnt_reg, cnt_next;
    logic                      bl_reg, bl_next;

    enc_res_t enc;
    logic     load;
    logic     pop;

    // Encode straight from the input register
    assign enc = encode_unit(unit_reg, last_reg, pend_reg, held_reg);

    // Reload the buffer when it is empty or its final byte leaves this cycle
    assign pop  = byte_ch.valid && byte_ch.ready;
    assign load = in_vld_reg && ((cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && byte_ch.ready));

    // Take a new unit whenever the input register is empty or moves on
    assign unit_ch.ready = !in_vld_reg || load;

    assign byte_ch.valid      = (cnt_reg != 3'd0);
    assign byte_ch.out_byte   = buf_reg[0];
    assign byte_ch.run_last   = (cnt_reg == 3'd1);
    assign byte_ch.string_end = (cnt_reg == 3'd1) && bl_reg;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (unit_ch.ready)
        begin
            in_vld_next = unit_ch.valid;
        end
    end

    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        bl_next   = bl_reg;
        pend_next = pend_reg;
        held_next = held_reg;
        if (load)
        begin
            // Advance the surrogate state with the unit leaving the input stage
            buf_next  = enc.bytes;
            cnt_next  = enc.count;
            bl_next   = last_reg;
            pend_next = enc.pending;
            held_next = enc.held;
        end
        else if (pop)
        begin
            buf_next = {8'h00, buf_reg[MAX_BYTES-1:1]};
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            cnt_reg    <= 3'd0;
            bl_reg     <= 1'b0;
            pend_reg   <= 1'b0;
            held_reg   <= 10'd0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            cnt_reg    <= cnt_next;
            bl_reg     <= bl_next;
            pend_reg   <= pend_next;
            held_reg   <= held_next;
        end
    end

    // Payload registers: hold until the next transaction, reload or shift
    always_ff @(posedge clk)
    begin
        if (unit_ch.valid && unit_ch.ready)
        begin
            unit_reg <= unit_ch.code_unit;
            last_reg <= unit_ch.string_last;
        end
        buf_reg <= buf_next;
    end

    // Held bits stay zero while no high surrogate is pending
    a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg |-> (held_reg == 10'd0))
        else $error("held surrogate bits nonzero while nothing is pending");

    // A unit that ends its string never leaves a surrogate pending
    a_flush_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_reg) |=> !pend_reg)
        else $error("high surrogate still pending after string end");

    // The buffer never holds more than one unit's worth of bytes
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd6)
        else $error("byte buffer count out of range");

    // A reload only happens when the buffer drains in the same cycle or is empty
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (cnt_reg != 3'd0)) |-> (pop && byte_ch.run_last))
        else $error("byte buffer reloaded while bytes remain");

    // A pending surrogate implies the last loaded unit did not end its string
    a_pend_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && enc.pending) |-> !last_reg)
        else $error("surrogate held on the last unit of a string");

endmodule
